FILE: hw/rtl/rtcm3fx_pkg.sv
package rtcm3fx_pkg;

  // pending byte buffer
  localparam int unsigned PEND_DEPTH = 2048;
  localparam int unsigned PEND_AW    = $clog2(PEND_DEPTH);
  localparam int unsigned CNT_W      = PEND_AW + 1;

  // frame limits
  localparam int unsigned FRAME_MAX  = 1029;
  localparam int unsigned FRAME_AW   = $clog2(FRAME_MAX + 1);
  localparam int unsigned ACC_AW     = FRAME_AW + 1;  // two banks
  localparam int unsigned MIN_FRAME  = 6;
  localparam int unsigned CRC_BYTES  = 3;

  localparam logic [7:0]  SYNC_BYTE   = 8'hD3;
  localparam logic [7:0]  LEN_HI_MASK = 8'hFC;
  localparam logic [24:0] CRC_POLY    = 25'h1864CFB;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef enum logic {
    RES_FRAME = 1'b0,
    RES_READ  = 1'b1
  } res_e;

  typedef struct packed {
    logic                kind;
    logic [7:0]          data_byte;
    logic [FRAME_AW-1:0] read_index;
  } item_t;

  // CRC-24Q, one byte, MSB first
  function automatic logic [23:0] crc24q_byte(logic [23:0] crc, logic [7:0] b);
    logic [24:0] t;
    t = {1'b0, crc[23:16] ^ b, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      t = {t[23:0], 1'b0};
      if (t[24]) begin
        t = t ^ CRC_POLY;
      end
    end
    return {crc[15:0], 8'h00} ^ t[23:0];
  endfunction

endpackage

FILE: hw/rtl/rtcm3fx_ifs.sv
interface rtcm3fx_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [7:0]                          data_byte;
  logic [rtcm3fx_pkg::FRAME_AW-1:0]    read_index;

  modport source (output valid, kind, data_byte, read_index, input ready);
  modport sink   (input valid, kind, data_byte, read_index, output ready);
endinterface

interface rtcm3fx_out_if;
  logic                                valid;
  logic                                ready;
  logic                                result_kind;
  logic [11:0]                         message_type;
  logic [rtcm3fx_pkg::FRAME_AW-1:0]    frame_len;
  logic [23:0]                         frame_crc;
  logic [7:0]                          read_byte;

  modport source (output valid, result_kind, message_type, frame_len, frame_crc, read_byte,
                  input ready);
  modport sink   (input valid, result_kind, message_type, frame_len, frame_crc, read_byte,
                  output ready);
endinterface

FILE: hw/rtl/rtcm3fx_front.sv
module rtcm3fx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  rtcm3fx_in_if.sink          in_i,
  output logic                q_valid_o,
  output rtcm3fx_pkg::item_t  q_item_o,
  input  logic                q_pop_i
);

  rtcm3fx_pkg::item_t q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= '{kind: in_i.kind, data_byte: in_i.data_byte,
                            read_index: in_i.read_index};
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue overfilled");

endmodule

FILE: hw/rtl/rtcm3fx_back.sv
module rtcm3fx_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  rtcm3fx_pkg::item_t                   q_item_i,
  output logic                                 q_pop_o,
  input  logic [rtcm3fx_pkg::FRAME_AW-1:0]     max_len_i,
  rtcm3fx_out_if.source                        out_o
);

  localparam int unsigned PAW = rtcm3fx_pkg::PEND_AW;
  localparam int unsigned CW  = rtcm3fx_pkg::CNT_W;
  localparam int unsigned FW  = rtcm3fx_pkg::FRAME_AW;
  localparam int unsigned AW  = rtcm3fx_pkg::ACC_AW;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SCAN0   = 10'b0000000010,
    S_HREQ    = 10'b0000000100,
    S_HDAT    = 10'b0000001000,
    S_LREQ    = 10'b0000010000,
    S_LDAT    = 10'b0000100000,
    S_CREQ    = 10'b0001000000,
    S_CDAT    = 10'b0010000000,
    S_CHECK   = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_e;

  function automatic logic [PAW-1:0] wrap_add(logic [PAW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(rtcm3fx_pkg::PEND_DEPTH)) begin
      s = s - (CW+1)'(rtcm3fx_pkg::PEND_DEPTH);
    end
    return s[PAW-1:0];
  endfunction

  logic [7:0] pend_mem [rtcm3fx_pkg::PEND_DEPTH];
  logic [7:0] acc_mem  [2**AW];

  state_e         state_q;
  logic [PAW-1:0] head_q;
  logic [CW-1:0]  count_q;
  logic [CW-1:0]  spos_q;
  logic [FW-1:0]  fpos_q, flen_q;
  logic [7:0]     prev_q;
  logic [1:0]     b1_q;
  logic [23:0]    crc_q, tail_q;
  logic [11:0]    typ_q;
  logic           bank_q;
  logic [FW-1:0]  acc_len_q, rd_idx_q;
  logic [11:0]    acc_type_q;
  logic [23:0]    acc_crc_q;
  logic           rkind_q;
  logic [7:0]     rbyte_q;

  // memory ports
  logic           pend_we, pend_re, acc_we, acc_re;
  logic [PAW-1:0] pend_waddr, pend_raddr;
  logic [AW-1:0]  acc_waddr, acc_raddr;
  logic [7:0]     pend_wdata, pend_rdata_q, acc_rdata_q;

  // push bookkeeping
  logic           full;
  logic [PAW-1:0] head1;
  logic [CW-1:0]  cnt1;

  logic           pair_hit;
  logic [CW-1:0]  left_cnt;
  logic [FW-1:0]  flen_c, limit;
  logic           out_free;

  logic           out_valid_q;
  logic           o_kind_q;
  logic [11:0]    o_type_q;
  logic [FW-1:0]  o_len_q;
  logic [23:0]    o_crc_q;
  logic [7:0]     o_byte_q;

  assign full  = (count_q == CW'(rtcm3fx_pkg::PEND_DEPTH));
  assign head1 = full ? wrap_add(head_q, CW'(1)) : head_q;
  assign cnt1  = full ? count_q - CW'(1) : count_q;

  assign pair_hit = (prev_q == rtcm3fx_pkg::SYNC_BYTE) &&
                    ((pend_rdata_q & rtcm3fx_pkg::LEN_HI_MASK) == 8'h00);
  assign left_cnt = count_q - spos_q + CW'(1);  // count after dropping the junk ahead
  assign flen_c   = FW'({b1_q, pend_rdata_q}) + FW'(rtcm3fx_pkg::MIN_FRAME);
  assign limit    = (max_len_i > FW'(rtcm3fx_pkg::FRAME_MAX)) ?
                    FW'(rtcm3fx_pkg::FRAME_MAX) : max_len_i;
  assign out_free = !out_valid_q || out_o.ready;

  assign pend_we    = (state_q == S_IDLE) && q_valid_i && (q_item_i.kind == rtcm3fx_pkg::KIND_PUSH);
  assign pend_waddr = wrap_add(head1, cnt1);
  assign pend_wdata = q_item_i.data_byte;
  assign pend_re    = (state_q == S_HREQ) || (state_q == S_LREQ) || (state_q == S_CREQ);

  always_comb begin
    case (state_q)
      S_HREQ:  pend_raddr = wrap_add(head_q, spos_q);
      S_LREQ:  pend_raddr = wrap_add(head_q, CW'(2));
      default: pend_raddr = wrap_add(head_q, CW'(fpos_q));
    endcase
  end

  assign acc_re    = (state_q == S_IDLE) && q_valid_i && (q_item_i.kind == rtcm3fx_pkg::KIND_READ);
  assign acc_raddr = {bank_q, q_item_i.read_index};
  assign acc_we    = (state_q == S_CDAT);
  assign acc_waddr = {~bank_q, fpos_q};

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    if (pend_re) pend_rdata_q <= pend_mem[pend_raddr];
    if (acc_we)  acc_mem[acc_waddr] <= pend_rdata_q;
    if (acc_re)  acc_rdata_q <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      bank_q     <= 1'b0;
      acc_len_q  <= '0;
      acc_type_q <= '0;
      acc_crc_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_OUT)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            if (q_item_i.kind == rtcm3fx_pkg::KIND_READ) begin
              state_q <= S_CHECK;  // read answer lands via S_CHECK's read arm
            end else begin
              head_q  <= head1;
              count_q <= cnt1 + CW'(1);
              state_q <= S_SCAN0;
            end
          end
        end
        S_SCAN0: begin
          state_q <= (count_q < CW'(3)) ? S_IDLE : S_HREQ;
        end
        S_HREQ: state_q <= S_HDAT;
        S_HDAT: begin
          if (spos_q == '0) begin
            state_q <= S_HREQ;
          end else if (pair_hit) begin
            head_q  <= wrap_add(head_q, spos_q - CW'(1));
            count_q <= left_cnt;
            state_q <= (left_cnt < CW'(rtcm3fx_pkg::MIN_FRAME)) ? S_IDLE : S_LREQ;
          end else if (spos_q + CW'(2) < count_q) begin
            state_q <= S_HREQ;
          end else begin
            // no sync: keep only the last two bytes
            head_q  <= wrap_add(head_q, count_q - CW'(2));
            count_q <= CW'(2);
            state_q <= S_IDLE;
          end
        end
        S_LREQ: state_q <= S_LDAT;
        S_LDAT: begin
          if (flen_c > limit) begin
            head_q  <= wrap_add(head_q, CW'(1));
            count_q <= count_q - CW'(1);
            state_q <= S_IDLE;
          end else if (count_q < CW'(flen_c)) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_CREQ;
          end
        end
        S_CREQ: state_q <= S_CDAT;
        S_CDAT: begin
          state_q <= (fpos_q == flen_q - FW'(1)) ? S_CHECK : S_CREQ;
        end
        S_CHECK: begin
          if (rkind_q == rtcm3fx_pkg::RES_READ) begin
            state_q <= S_OUT;
          end else if (crc_q == tail_q) begin
            bank_q     <= ~bank_q;
            acc_len_q  <= flen_q;
            acc_type_q <= typ_q;
            acc_crc_q  <= tail_q;
            head_q     <= wrap_add(head_q, CW'(flen_q));
            count_q    <= count_q - CW'(flen_q);
            state_q    <= S_OUT;
          end else begin
            head_q  <= wrap_add(head_q, CW'(1));
            count_q <= count_q - CW'(1);
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        spos_q   <= '0;
        rd_idx_q <= q_item_i.read_index;
        rkind_q  <= (q_item_i.kind == rtcm3fx_pkg::KIND_READ) ?
                    rtcm3fx_pkg::RES_READ : rtcm3fx_pkg::RES_FRAME;
      end
      S_HDAT: begin
        prev_q <= pend_rdata_q;
        b1_q   <= pend_rdata_q[1:0];
        spos_q <= spos_q + CW'(1);
      end
      S_LDAT: begin
        flen_q <= flen_c;
        fpos_q <= '0;
        crc_q  <= '0;
      end
      S_CDAT: begin
        if (fpos_q < flen_q - FW'(rtcm3fx_pkg::CRC_BYTES)) begin
          crc_q <= rtcm3fx_pkg::crc24q_byte(crc_q, pend_rdata_q);
        end else begin
          tail_q <= {tail_q[15:0], pend_rdata_q};
        end
        if (fpos_q == FW'(3)) typ_q[11:4] <= pend_rdata_q;
        if (fpos_q == FW'(4)) typ_q[3:0]  <= pend_rdata_q[7:4];
        fpos_q <= fpos_q + FW'(1);
      end
      S_CHECK: begin
        rbyte_q <= ((rkind_q == rtcm3fx_pkg::RES_READ) && (rd_idx_q < acc_len_q)) ?
                   acc_rdata_q : 8'h00;
      end
      S_OUT: begin
        if (out_free) begin
          o_kind_q <= rkind_q;
          o_type_q <= acc_type_q;
          o_len_q  <= acc_len_q;
          o_crc_q  <= acc_crc_q;
          o_byte_q <= rbyte_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = o_kind_q;
  assign out_o.message_type = o_type_q;
  assign out_o.frame_len    = o_len_q;
  assign out_o.frame_crc    = o_crc_q;
  assign out_o.read_byte    = o_byte_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(rtcm3fx_pkg::PEND_DEPTH)) else $error("pending count overflow");

  a_acc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_len_q == '0 || (acc_len_q >= FW'(rtcm3fx_pkg::MIN_FRAME) &&
                        acc_len_q <= FW'(rtcm3fx_pkg::FRAME_MAX)))
    else $error("accepted length out of range");

  a_accept_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && rkind_q == rtcm3fx_pkg::RES_FRAME && crc_q == tail_q)
      |=> (acc_len_q == $past(flen_q)))
    else $error("accepted frame length not latched");

endmodule

FILE: hw/rtl/rtcm3_frame_extractor.sv
// RTCM3 frame extractor. Beats on in_i either push one received byte (kind 0) or read a byte
// of the last good frame (kind 1, read_index). The block hunts for 0xD3 plus a length byte with
// its top six bits clear, checks the length against max_frame_len (capped at 1029) and the
// CRC-24Q, and on success emits one report beat on out_o (type, length, CRC); a read always
// emits one answer beat. A false sync drops one byte and the rest is rescanned on the next push.
// A 2-entry input queue decouples in_i from the engine; the engine takes one beat at a time.
// Per beat: a read goes through S_CHECK and S_OUT; a push goes through S_SCAN0, then examines
// the buffered bytes one by one in the header search (usually one pair, since a waiting frame
// sits at the head), then reads the length byte and, once the frame is complete, makes the CRC
// pass over every frame byte, then compares the CRC and, on a good frame, hands the report over.
// Each pending-buffer byte is read in a request state and used in its data state, which sets
// the pace. Results leave through an output register, so a stalled out_o only blocks the engine
// once it has its next result ready. cfg_we_i/cfg_wdata_i write max_frame_len (reset 1029).
module rtcm3_frame_extractor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rtcm3fx_in_if.sink                        in_i,
  rtcm3fx_out_if.source                     out_o,
  input  logic                              cfg_we_i,
  input  logic [rtcm3fx_pkg::FRAME_AW-1:0]  cfg_wdata_i
);

  logic [rtcm3fx_pkg::FRAME_AW-1:0] max_len_q;
  logic                             q_valid, q_pop;
  rtcm3fx_pkg::item_t               q_item;

  // max_frame_len register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= rtcm3fx_pkg::FRAME_AW'(rtcm3fx_pkg::FRAME_MAX);
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // front: takes beats, queues them
  rtcm3fx_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // back: buffer, sync search, CRC check, frame store, result register
  rtcm3fx_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .max_len_i (max_len_q),
    .out_o     (out_o)
  );

endmodule
